// ===== rtl/core/fcb_pkg.sv =====
package fcb_pkg;

    // frame geometry
    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 240;

    // field widths
    localparam int PIX_W  = 8;
    localparam int COL_W  = 9;
    localparam int ROW_W  = 8;
    localparam int CFG_W  = 9;
    localparam int IDX_W  = 3;
    localparam int SUM_W  = PIX_W + 3;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_X_LOW  = 3'd0;
    localparam logic [IDX_W-1:0] REG_X_HIGH = 3'd1;
    localparam logic [IDX_W-1:0] REG_Y_LOW  = 3'd2;
    localparam logic [IDX_W-1:0] REG_Y_HIGH = 3'd3;
    localparam logic [IDX_W-1:0] REG_DECAY  = 3'd4;

    // reset values of the configuration registers
    localparam logic [COL_W-1:0] X_LOW_RST  = COL_W'(1);
    localparam logic [COL_W-1:0] X_HIGH_RST = COL_W'(FRAME_WIDTH - 1);
    localparam logic [ROW_W-1:0] Y_LOW_RST  = ROW_W'(1);
    localparam logic [ROW_W-1:0] Y_HIGH_RST = ROW_W'(FRAME_HEIGHT - 1);
    localparam logic [PIX_W-1:0] DECAY_RST  = PIX_W'(4);

    typedef struct packed {
        logic [COL_W-1:0] x_low;
        logic [COL_W-1:0] x_high;
        logic [ROW_W-1:0] y_low;
        logic [ROW_W-1:0] y_high;
        logic [PIX_W-1:0] decay;
    } cfg_t;

    // 3x3 neighborhood around the pixel being finished
    typedef struct packed {
        logic [PIX_W-1:0] up_left;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] up_right;
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] center;
        logic [PIX_W-1:0] right;
        logic [PIX_W-1:0] down_left;
        logic [PIX_W-1:0] down;
        logic [PIX_W-1:0] down_right;
    } win_t;

    // first or last column, first or last row
    function automatic logic on_border(input logic [COL_W-1:0] x, input logic [ROW_W-1:0] y);
        on_border = (x == '0) || (x >= COL_W'(FRAME_WIDTH - 1)) ||
                    (y == '0) || (y >= ROW_W'(FRAME_HEIGHT - 1));
    endfunction

endpackage

// ===== rtl/core/fcb_ram.sv =====
module fcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 320
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/fcb_cfg.sv =====
module fcb_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [fcb_pkg::IDX_W-1:0]   cfg_index,
    input  logic [fcb_pkg::CFG_W-1:0]   cfg_data,
    output fcb_pkg::cfg_t               cfg
);

    import fcb_pkg::*;

    cfg_t cfg_reg;

    // register writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_low  <= X_LOW_RST;
            cfg_reg.x_high <= X_HIGH_RST;
            cfg_reg.y_low  <= Y_LOW_RST;
            cfg_reg.y_high <= Y_HIGH_RST;
            cfg_reg.decay  <= DECAY_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_X_LOW:  cfg_reg.x_low  <= cfg_data[COL_W-1:0];
                REG_X_HIGH: cfg_reg.x_high <= cfg_data[COL_W-1:0];
                REG_Y_LOW:  cfg_reg.y_low  <= cfg_data[ROW_W-1:0];
                REG_Y_HIGH: cfg_reg.y_high <= cfg_data[ROW_W-1:0];
                REG_DECAY:  cfg_reg.decay  <= cfg_data[PIX_W-1:0];
                default:    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/fcb_kernel.sv =====
module fcb_kernel (
    input  fcb_pkg::win_t               win,
    input  logic [fcb_pkg::COL_W-1:0]   px,
    input  logic [fcb_pkg::ROW_W-1:0]   py,
    input  fcb_pkg::cfg_t               cfg,
    output logic [fcb_pkg::PIX_W-1:0]   heat,
    output logic                        burn
);

    import fcb_pkg::*;

    logic [SUM_W-1:0] sum;
    logic [PIX_W-1:0] avg;
    logic             in_region;
    logic             border;
    logic             filt;
    logic             hot;

    // eight-neighbor sum, center excluded
    assign sum = SUM_W'(win.up_left) + SUM_W'(win.up) + SUM_W'(win.up_right)
               + SUM_W'(win.left) + SUM_W'(win.right)
               + SUM_W'(win.down_left) + SUM_W'(win.down) + SUM_W'(win.down_right);
    assign avg = sum[SUM_W-1:3];

    // region test and cooling clamp
    assign border    = on_border(px, py);
    assign in_region = (px >= cfg.x_low) && (px < cfg.x_high) &&
                       (py >= cfg.y_low) && (py < cfg.y_high);
    assign filt      = !border && in_region;
    assign hot       = avg > cfg.decay;
    assign burn      = filt && hot;

    always_comb
    begin
        if (border)
        begin
            heat = '0;
        end
        else if (filt)
        begin
            heat = hot ? (avg - cfg.decay) : '0;
        end
        else
        begin
            heat = win.center;
        end
    end

endmodule

// ===== rtl/core/fire_cooling_blur_filter_core.sv =====
// channel  | handshake                    | payload
// pixel    | pixel_valid / pixel_ready    | heat_in, frame_start
// result   | result_valid / result_ready  | heat_out, out_column, out_row,
//          |                              | frame_last, still_burning
// config   | cfg_write                    | cfg_index, cfg_data
//
// one pixel per cycle sustained while results are taken; a pixel waits in the input stage and its
// result (if any) is loaded into the result register as the pixel leaves that stage
// each result belongs to the pixel one row plus one column behind the current input,
// read from two line stores (one read port each, prefetched at accept time)
// the first row plus one pixel of a frame give no result
// reset clears counters, window and flags; line stores are not cleared
// a stalled result blocks input once the input stage holds a pixel with a result;
// until then one more pixel is taken into the empty input stage
module fire_cooling_blur_filter_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pixel_valid,
    output logic                        pixel_ready,
    input  logic [fcb_pkg::PIX_W-1:0]   heat_in,
    input  logic                        frame_start,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [fcb_pkg::PIX_W-1:0]   heat_out,
    output logic [fcb_pkg::COL_W-1:0]   out_column,
    output logic [fcb_pkg::ROW_W-1:0]   out_row,
    output logic                        frame_last,
    output logic                        still_burning,
    input  logic                        cfg_write,
    input  logic [fcb_pkg::IDX_W-1:0]   cfg_index,
    input  logic [fcb_pkg::CFG_W-1:0]   cfg_data
);

    import fcb_pkg::*;

    cfg_t             cfg;
    logic             accept;
    logic [COL_W-1:0] col_in;
    logic [ROW_W-1:0] row_in;
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;

    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [PIX_W-1:0] s1_heat_reg;
    logic             s1_fire;
    logic             s1_emit;
    logic             s1_last;
    logic [COL_W-1:0] ex;
    logic [ROW_W-1:0] ey;
    logic [PIX_W-1:0] pix_v;

    logic [PIX_W-1:0] upd_rd;
    logic [PIX_W-1:0] old_rd;
    logic [PIX_W-1:0] up_prev_reg;
    logic [PIX_W-1:0] old_d1_reg;
    logic [PIX_W-1:0] old_d2_reg;
    logic [PIX_W-1:0] win_ul_reg;
    logic [PIX_W-1:0] win_l_reg;
    logic [PIX_W-1:0] win_c_reg;
    win_t             win;
    logic [PIX_W-1:0] res;
    logic             burn;
    logic             frame_first;
    logic             burning_reg, burning_next;

    logic             result_valid_reg, result_valid_next;
    logic [PIX_W-1:0] heat_out_reg;
    logic [COL_W-1:0] col_out_reg;
    logic [ROW_W-1:0] row_out_reg;
    logic             last_out_reg;
    logic             burn_out_reg;

    fcb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // handshake: input stage frees when its pixel moves on
    assign s1_fire     = s1_valid_reg && (!s1_emit || !result_valid_reg || result_ready);
    assign pixel_ready = !s1_valid_reg || s1_fire;
    assign accept      = pixel_valid && pixel_ready;

    // position of the incoming pixel
    assign col_in = frame_start ? '0 : col_cnt_reg;
    assign row_in = frame_start ? '0 : row_cnt_reg;

    always_comb
    begin
        col_cnt_next = col_in + COL_W'(1);
        row_cnt_next = row_in;
        if (col_in == COL_W'(FRAME_WIDTH - 1))
        begin
            col_cnt_next = '0;
            row_cnt_next = (row_in == ROW_W'(FRAME_HEIGHT - 1)) ? '0 : row_in + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg  <= col_in;
            s1_row_reg  <= row_in;
            s1_heat_reg <= heat_in;
        end
    end

    // pixel being finished lags one row plus one column
    assign s1_emit = (s1_row_reg >= ROW_W'(2)) ||
                     ((s1_row_reg == ROW_W'(1)) && (s1_col_reg != '0));
    assign s1_last = (s1_col_reg == COL_W'(FRAME_WIDTH - 1)) &&
                     (s1_row_reg == ROW_W'(FRAME_HEIGHT - 1));
    assign ex      = (s1_col_reg != '0) ? s1_col_reg - COL_W'(1) : COL_W'(FRAME_WIDTH - 1);
    assign ey      = (s1_col_reg != '0) ? s1_row_reg - ROW_W'(1) : s1_row_reg - ROW_W'(2);
    assign pix_v   = on_border(s1_col_reg, s1_row_reg) ? '0 : s1_heat_reg;

    // line of finished values from the row above
    fcb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FRAME_WIDTH)
    ) u_upd_line (
        .clk     (clk),
        .wr_en   (s1_fire && s1_emit),
        .wr_addr (ex),
        .wr_data (res),
        .rd_en   (accept),
        .rd_addr (col_in),
        .rd_data (upd_rd)
    );

    // line of original values, one row of delay
    fcb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FRAME_WIDTH)
    ) u_old_line (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (pix_v),
        .rd_en   (accept),
        .rd_addr (col_in),
        .rd_data (old_rd)
    );

    // neighborhood assembly
    assign win.up_left    = win_ul_reg;
    assign win.up         = up_prev_reg;
    assign win.up_right   = upd_rd;
    assign win.left       = win_l_reg;
    assign win.center     = win_c_reg;
    assign win.right      = old_rd;
    assign win.down_left  = old_d2_reg;
    assign win.down       = old_d1_reg;
    assign win.down_right = pix_v;

    fcb_kernel u_kernel (
        .win  (win),
        .px   (ex),
        .py   (ey),
        .cfg  (cfg),
        .heat (res),
        .burn (burn)
    );

    // window slides one column per pixel leaving the input stage; left part only per finished pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_prev_reg <= '0;
            old_d1_reg  <= '0;
            old_d2_reg  <= '0;
            win_ul_reg  <= '0;
            win_l_reg   <= '0;
            win_c_reg   <= '0;
        end
        else if (s1_fire)
        begin
            up_prev_reg <= upd_rd;
            old_d1_reg  <= pix_v;
            old_d2_reg  <= old_d1_reg;
            if (s1_emit)
            begin
                win_ul_reg <= up_prev_reg;
                win_l_reg  <= res;
                win_c_reg  <= old_rd;
            end
        end
    end

    // burning flag restarts with every frame
    assign frame_first  = (s1_col_reg == '0) && (s1_row_reg == '0);
    assign burning_next = (burning_reg && !frame_first) || (s1_emit && burn);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burning_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            burning_reg <= burning_next;
        end
    end

    // result register
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (s1_fire && s1_emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_emit)
        begin
            heat_out_reg <= res;
            col_out_reg  <= ex;
            row_out_reg  <= ey;
            last_out_reg <= s1_last;
            burn_out_reg <= s1_last && burning_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign heat_out      = heat_out_reg;
    assign out_column    = col_out_reg;
    assign out_row       = row_out_reg;
    assign frame_last    = last_out_reg;
    assign still_burning = burn_out_reg;

endmodule

// ===== rtl/core/fcb_checker.sv =====
module fcb_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  logic [fcb_pkg::PIX_W-1:0]   heat_out,
    input  logic [fcb_pkg::COL_W-1:0]   out_column,
    input  logic [fcb_pkg::ROW_W-1:0]   out_row,
    input  logic                        frame_last,
    input  logic                        still_burning
);

    import fcb_pkg::*;

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(heat_out) &&
        $stable(out_column) && $stable(out_row))
        else $error("result beat changed while stalled");

    // the frame's final beat is the last interior pixel
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_last |->
        out_column == COL_W'(FRAME_WIDTH - 2) && out_row == ROW_W'(FRAME_HEIGHT - 2))
        else $error("frame_last on wrong pixel");

    // burning status only on the final beat
    a_burn_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !frame_last |-> !still_burning)
        else $error("still_burning outside frame end");

    // border pixels come out cold
    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (out_column == '0 || out_row == '0 ||
        out_column >= COL_W'(FRAME_WIDTH - 1) || out_row >= ROW_W'(FRAME_HEIGHT - 1))
        |-> heat_out == '0)
        else $error("border pixel not zero");

endmodule

bind fire_cooling_blur_filter_core fcb_checker u_fcb_checker (.*);

// ===== sim/fire_cooling_blur_checker.sv =====
module fire_cooling_blur_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pixel_valid,
    input  logic                        pixel_ready,
    input  logic [fcb_pkg::PIX_W-1:0]   heat_in,
    input  logic                        frame_start,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  logic [fcb_pkg::PIX_W-1:0]   heat_out,
    input  logic [fcb_pkg::COL_W-1:0]   out_column,
    input  logic [fcb_pkg::ROW_W-1:0]   out_row,
    input  logic                        frame_last,
    input  logic                        still_burning,
    input  logic                        cfg_write,
    input  logic [fcb_pkg::IDX_W-1:0]   cfg_index,
    input  logic [fcb_pkg::CFG_W-1:0]   cfg_data,
    output int                          mismatch_count,
    output int                          pixels_owed
);

    import fcb_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] heat;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             last;
        logic             burning;
    } cooled_pixel_t;

    // copy of the register file as written through the config port
    cfg_t             regs;

    // line buffers: cooled values of the row above, raw values of the current row
    logic [PIX_W-1:0] cooled_line [FRAME_WIDTH];
    logic [PIX_W-1:0] raw_line    [FRAME_WIDTH];
    win_t             nbr;
    logic [COL_W-1:0] next_col;
    logic [ROW_W-1:0] next_row;
    logic             burning;

    cooled_pixel_t    cooled_q [$];

    function automatic logic at_frame_rim(input int x, input int y);
        return x == 0 || x >= FRAME_WIDTH - 1 || y == 0 || y >= FRAME_HEIGHT - 1;
    endfunction

    // one raster pixel in, possibly one cooled pixel out
    task automatic cool_pixel(input logic [PIX_W-1:0] heat, input logic restart);
        int               col;
        int               row;
        int               ex;
        int               ey;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] cooled;
        logic [SUM_W-1:0] sum;
        logic [PIX_W-1:0] avg;
        logic             emit;
        logic             last;
        cooled_pixel_t    want;
        if (restart)
        begin
            next_col = '0;
            next_row = '0;
        end
        col = int'(next_col);
        row = int'(next_row);
        if (col == 0 && row == 0)
            burning = 1'b0;

        pix  = at_frame_rim(col, row) ? '0 : heat;
        emit = (row >= 2) || (row == 1 && col >= 1);
        last = (col == FRAME_WIDTH - 1) && (row == FRAME_HEIGHT - 1);

        if (emit)
        begin
            // the finished pixel sits one row and one column behind the input
            if (col >= 1)
            begin
                ex = col - 1;
                ey = row - 1;
            end
            else
            begin
                ex = FRAME_WIDTH - 1;
                ey = row - 2;
            end

            nbr.up         = cooled_line[ex];
            nbr.up_right   = (ex + 1 < FRAME_WIDTH) ? cooled_line[ex + 1] : '0;
            nbr.right      = raw_line[col];
            nbr.down_left  = (ex >= 1) ? raw_line[ex - 1] : '0;
            nbr.down       = raw_line[ex];
            nbr.down_right = pix;

            if (at_frame_rim(ex, ey))
                cooled = '0;
            else if (ex >= regs.x_low && ex < regs.x_high &&
                     ey >= regs.y_low && ey < regs.y_high)
            begin
                sum = SUM_W'(nbr.up_left) + SUM_W'(nbr.up) + SUM_W'(nbr.up_right) +
                      SUM_W'(nbr.left) + SUM_W'(nbr.right) + SUM_W'(nbr.down_left) +
                      SUM_W'(nbr.down) + SUM_W'(nbr.down_right);
                avg = sum[SUM_W-1:3];
                if (avg > regs.decay)
                begin
                    cooled  = avg - regs.decay;
                    burning = 1'b1;
                end
                else
                    cooled = '0;
            end
            else
                cooled = nbr.center;

            cooled_line[ex] = cooled;
            // slide the window one column to the right
            nbr.up_left = nbr.up;
            nbr.left    = cooled;
            nbr.center  = nbr.right;

            want.heat    = cooled;
            want.column  = COL_W'(ex);
            want.row     = ROW_W'(ey);
            want.last    = last;
            want.burning = last ? burning : 1'b0;
            cooled_q.push_back(want);
        end

        raw_line[col] = pix;

        col++;
        if (col >= FRAME_WIDTH)
        begin
            col = 0;
            row++;
            if (row >= FRAME_HEIGHT)
                row = 0;
        end
        next_col = COL_W'(col);
        next_row = ROW_W'(row);
    endtask

    task automatic compare_field(input string field, input logic [COL_W-1:0] want,
                                 input logic [COL_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cooled_pixel_t want;
        if (!rst_n)
        begin
            regs.x_low     = X_LOW_RST;
            regs.x_high    = X_HIGH_RST;
            regs.y_low     = Y_LOW_RST;
            regs.y_high    = Y_HIGH_RST;
            regs.decay     = DECAY_RST;
            for (int i = 0; i < FRAME_WIDTH; i++)
            begin
                cooled_line[i] = '0;
                raw_line[i]    = '0;
            end
            nbr            = '0;
            next_col       = '0;
            next_row       = '0;
            burning        = 1'b0;
            cooled_q.delete();
            mismatch_count = 0;
            pixels_owed    = 0;
        end
        else
        begin
            // result beat against the oldest prediction
            if (result_valid && result_ready)
            begin
                if (cooled_q.size() == 0)
                begin
                    $error("result beat with nothing expected: column %0d row %0d",
                           out_column, out_row);
                    mismatch_count++;
                end
                else
                begin
                    want = cooled_q.pop_front();
                    compare_field("heat_out", COL_W'(want.heat), COL_W'(heat_out));
                    compare_field("out_column", want.column, out_column);
                    compare_field("out_row", COL_W'(want.row), COL_W'(out_row));
                    compare_field("frame_last", COL_W'(want.last), COL_W'(frame_last));
                    compare_field("still_burning", COL_W'(want.burning),
                                  COL_W'(still_burning));
                end
            end

            // pixel beat
            if (pixel_valid && pixel_ready)
                cool_pixel(heat_in, frame_start);

            // register writes
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_X_LOW:  regs.x_low  = cfg_data;
                    REG_X_HIGH: regs.x_high = cfg_data;
                    REG_Y_LOW:  regs.y_low  = cfg_data[ROW_W-1:0];
                    REG_Y_HIGH: regs.y_high = cfg_data[ROW_W-1:0];
                    REG_DECAY:  regs.decay  = cfg_data[PIX_W-1:0];
                    default: ;
                endcase
            end

            pixels_owed = cooled_q.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
module testbench;

    import fcb_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int DRAIN_LIMIT  = 20_000;

    typedef enum int {
        HEAT_UNIFORM,
        HEAT_EMBERS,
        HEAT_BLAZE,
        HEAT_EXTREMES
    } heat_mix_e;

    logic             clk;
    logic             rst_n;
    logic             pixel_valid;
    logic             pixel_ready;
    logic [PIX_W-1:0] heat_in;
    logic             frame_start;
    logic             result_valid;
    logic             result_ready;
    logic [PIX_W-1:0] heat_out;
    logic [COL_W-1:0] out_column;
    logic [ROW_W-1:0] out_row;
    logic             frame_last;
    logic             still_burning;
    logic             cfg_write;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int               mismatch_count;
    int               pixels_owed;
    bit               gaps_on = 1'b1;

    fire_cooling_blur_filter_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel_valid   (pixel_valid),
        .pixel_ready   (pixel_ready),
        .heat_in       (heat_in),
        .frame_start   (frame_start),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .heat_out      (heat_out),
        .out_column    (out_column),
        .out_row       (out_row),
        .frame_last    (frame_last),
        .still_burning (still_burning),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    fire_cooling_blur_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .heat_in        (heat_in),
        .frame_start    (frame_start),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .heat_out       (heat_out),
        .out_column     (out_column),
        .out_row        (out_row),
        .frame_last     (frame_last),
        .still_burning  (still_burning),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pixels_owed    (pixels_owed)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle counter guarding against a hang
    initial
    begin : watchdog
        int unsigned cycle_count;
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("fire_cooling_blur_filter_core regression: fail");
        $finish;
    end

    // result side backpressure in bursts
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (gaps_on && rst_n && $urandom_range(0, 11) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge clk);
            end
            else
                result_ready <= 1'b1;
        end
    end

    function automatic logic [PIX_W-1:0] pick_heat(input heat_mix_e mix);
        case (mix)
            HEAT_EMBERS:   return PIX_W'($urandom_range(0, 15));
            HEAT_BLAZE:    return PIX_W'($urandom_range(200, 255));
            HEAT_EXTREMES: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:       return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // one pixel beat, with an occasional idle burst ahead of it
    task automatic send_pixel(input logic [PIX_W-1:0] heat, input logic mark);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        pixel_valid <= 1'b1;
        heat_in     <= heat;
        frame_start <= mark;
        do
            @(posedge clk);
        while (!pixel_ready);
    endtask

    task automatic run_frame(input int count, input logic mark, input heat_mix_e mix,
                             input bit noisy);
        logic restart;
        for (int i = 0; i < count; i++)
        begin
            // noisy frames may get cut short by a stray frame start
            restart = (i == 0) ? mark : (noisy && $urandom_range(0, 39) == 0);
            send_pixel(pick_heat(mix), restart);
        end
    endtask

    task automatic run_constant(input int count, input logic [PIX_W-1:0] heat);
        for (int i = 0; i < count; i++)
            send_pixel(heat, i == 0);
    endtask

    // drop valid and wait until every predicted pixel has come out
    task automatic settle;
        @(negedge clk);
        pixel_valid <= 1'b0;
        wait (pixels_owed == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic apply_settings(input logic [COL_W-1:0] xl, input logic [COL_W-1:0] xh,
                                  input logic [ROW_W-1:0] yl, input logic [ROW_W-1:0] yh,
                                  input logic [PIX_W-1:0] decay);
        settle();
        write_reg(REG_X_LOW, xl);
        write_reg(REG_X_HIGH, xh);
        write_reg(REG_Y_LOW, CFG_W'(yl));
        write_reg(REG_Y_HIGH, CFG_W'(yh));
        write_reg(REG_DECAY, CFG_W'(decay));
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n       = 1'b0;
        pixel_valid = 1'b0;
        heat_in     = '0;
        frame_start = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = REG_X_LOW;
        cfg_data    = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // straight out of reset with no frame start, then restarts mid-row
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h55, 1'b0);
        send_pixel(8'hAA, 1'b0);
        send_pixel(8'h0F, 1'b0);
        send_pixel(8'hF0, 1'b0);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h80, 1'b1);
        send_pixel(8'h01, 1'b0);

        // saturated start of a frame under the reset settings
        run_constant(40, 8'hFF);

        // region spilling past the frame edges, then pass-through columns;
        // long enough to reach the first filtered row
        apply_settings(9'd0, 9'd30, 8'd0, 8'd255, PIX_W'($urandom_range(60, 200)));
        run_frame(700, 1'b1, HEAT_EXTREMES, 0);

        // inverted region with stray frame starts
        apply_settings(9'd300, 9'd10, 8'd200, 8'd3, 8'd7);
        run_frame(40, 1'b1, HEAT_UNIFORM, 1);

        // frame keeps going without a frame start, at full rate
        gaps_on = 1'b0;
        run_frame(60, 1'b0, HEAT_BLAZE, 0);

        @(negedge clk);
        pixel_valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && pixels_owed != 0; n++)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (pixels_owed != 0)
            $error("%0d predicted pixels never came out", pixels_owed);

        if (mismatch_count == 0 && pixels_owed == 0)
            $display("fire_cooling_blur_filter_core regression: pass");
        else
            $display("fire_cooling_blur_filter_core regression: fail");
        $finish;
    end

endmodule
